FILE: rtl/lbps_pkg.sv
`timescale 1ns / 1ps

package lbps_pkg;

  // Pattern codes, shared by pattern_sel and active_pattern.
  localparam logic [2:0] PAT_TEMPO   = 3'd0;
  localparam logic [2:0] PAT_HELD    = 3'd1;
  localparam logic [2:0] PAT_SAVING  = 3'd2;
  localparam logic [2:0] PAT_LOADING = 3'd3;
  localparam logic [2:0] PAT_ERROR   = 3'd4;
  localparam logic [2:0] PAT_MIRROR  = 3'd5;

  localparam logic [0:0] FUNC_TICK    = 1'b0;
  localparam logic [0:0] FUNC_TRIGGER = 1'b1;

  localparam logic [15:0] TEMPO_PULSE_RESET = 16'd50;

  // Configuration register index, taken from paddr[2].
  localparam logic [0:0] REG_TEMPO_PULSE = 1'b0;

  typedef struct packed {
    logic        func;
    logic [2:0]  pattern_sel;
    logic [31:0] now_ms;
  } in_item_t;

  typedef struct packed {
    logic       led_on;
    logic       led_write;
    logic [2:0] active_pattern;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  cur_pattern;
    logic        lamp_lit;
    logic [31:0] pattern_start_ms;
    logic [31:0] phase_start_ms;
  } seq_state_t;

  // Remainder of a 32-bit value by 2000. 2000 = 16 * 125, and 128 is 3 modulo 125,
  // so the upper 28 bits are folded in 7-bit digits weighted by powers of three.
  function automatic logic [10:0] mod2000(input logic [31:0] x);
    logic [27:0] y;
    logic [12:0] s;
    logic [7:0]  t;
    logic [6:0]  m;
    y = x[31:4];
    s = 13'(y[6:0]) + 13'(y[13:7]) * 13'd3 + 13'(y[20:14]) * 13'd9
        + 13'(y[27:21]) * 13'd27;
    t = 8'(s[6:0]) + 8'(s[12:7]) * 8'd3;
    if (t >= 8'd125) begin
      m = 7'(t - 8'd125);
    end else begin
      m = t[6:0];
    end
    return {m, x[3:0]};
  endfunction

endpackage

FILE: rtl/lbps_step.sv
`timescale 1ns / 1ps

module lbps_step (
  input  lbps_pkg::in_item_t   item,
  input  lbps_pkg::seq_state_t st,
  input  logic [15:0]          tempo_pulse_ms,
  output lbps_pkg::seq_state_t st_nxt,
  output lbps_pkg::out_item_t  res
);
  import lbps_pkg::*;

  logic [31:0] pat_el;
  logic [31:0] ph_el;
  logic [10:0] pat_mod;
  logic        follow_en;
  logic        follow_lvl;
  logic        wrote;

  assign pat_el  = item.now_ms - st.pattern_start_ms;
  assign ph_el   = item.now_ms - st.phase_start_ms;
  assign pat_mod = mod2000(pat_el);

  always_comb begin
    st_nxt     = st;
    wrote      = 1'b0;
    follow_en  = 1'b0;
    follow_lvl = 1'b0;
    if (item.func == FUNC_TRIGGER) begin
      st_nxt.cur_pattern      = (item.pattern_sel <= PAT_MIRROR) ? item.pattern_sel
                                                                 : PAT_TEMPO;
      st_nxt.pattern_start_ms = item.now_ms;
      st_nxt.phase_start_ms   = item.now_ms;
      st_nxt.lamp_lit         = 1'b1;
      wrote                   = 1'b1;
    end else begin
      case (st.cur_pattern)
        PAT_HELD: begin
          if (pat_el < 32'd400) begin
            follow_en  = 1'b1;
            follow_lvl = (pat_el < 32'd100) || (pat_el >= 32'd150 && pat_el < 32'd250);
          end else begin
            st_nxt.pattern_start_ms = item.now_ms;
          end
        end
        PAT_SAVING: begin
          // Five blinks, one per 200 ms period, end at 1000 ms.
          if (ph_el >= 32'd1000) begin
            st_nxt.cur_pattern = PAT_TEMPO;
            st_nxt.lamp_lit    = 1'b0;
            wrote              = 1'b1;
          end else begin
            follow_en  = 1'b1;
            follow_lvl = (ph_el < 32'd100) || (ph_el >= 32'd200 && ph_el < 32'd300)
                      || (ph_el >= 32'd400 && ph_el < 32'd500)
                      || (ph_el >= 32'd600 && ph_el < 32'd700)
                      || (ph_el >= 32'd800 && ph_el < 32'd900);
          end
        end
        PAT_LOADING: begin
          follow_en  = 1'b1;
          follow_lvl = pat_mod < 11'd1000;
        end
        PAT_ERROR: begin
          // Three blinks, one per 100 ms period, end at 300 ms.
          if (ph_el >= 32'd300) begin
            st_nxt.cur_pattern = PAT_TEMPO;
            st_nxt.lamp_lit    = 1'b0;
            wrote              = 1'b1;
          end else begin
            follow_en  = 1'b1;
            follow_lvl = (ph_el < 32'd50) || (ph_el >= 32'd100 && ph_el < 32'd150)
                      || (ph_el >= 32'd200 && ph_el < 32'd250);
          end
        end
        PAT_MIRROR: begin
          if (pat_el < 32'd300) begin
            follow_en  = 1'b1;
            follow_lvl = pat_el < 32'd200;
          end else begin
            st_nxt.pattern_start_ms = item.now_ms;
          end
        end
        default: begin
          if (st.lamp_lit && ph_el >= 32'(tempo_pulse_ms)) begin
            st_nxt.lamp_lit = 1'b0;
            wrote           = 1'b1;
          end
        end
      endcase
      if (follow_en && follow_lvl != st.lamp_lit) begin
        st_nxt.lamp_lit = follow_lvl;
        wrote           = 1'b1;
      end
    end
  end

  assign res.led_on         = st_nxt.lamp_lit;
  assign res.led_write      = wrote;
  assign res.active_pattern = st_nxt.cur_pattern;

endmodule

FILE: rtl/led_blink_pattern_sequencer.sv
`timescale 1ns / 1ps

// LED blink pattern sequencer. Each item carries a millisecond timestamp and is either a
// trigger, which selects a pattern, restarts both time bases and lights the LED, or a tick,
// which advances the active pattern; every item yields exactly one result item giving the
// LED level, whether the pin was driven and the pattern in force. Items pass through an
// input register and are worked out combinationally into the result register, so one item
// is taken every cycle while the result channel is not stalled; its result item is
// offered once the item moves into the result register. The combinational update of the
// pattern state sets this rate. The input register also acts as a skid stage, so one
// further item is taken while a finished result waits for the consumer. The pulse
// length of the tempo pattern sits in the only configuration register, at byte address 0.

module led_blink_pattern_sequencer (
  input  logic                clk,
  input  logic                rst_n,
  // Input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  lbps_pkg::in_item_t  in_item,
  // Result channel
  output logic                out_valid,
  input  logic                out_stall,
  output lbps_pkg::out_item_t out_item,
  // Configuration port
  input  logic                cfg_psel,
  input  logic                cfg_penable,
  input  logic                cfg_pwrite,
  input  logic [2:0]          cfg_paddr,
  input  logic [31:0]         cfg_pwdata,
  output logic [31:0]         cfg_prdata,
  output logic                cfg_pready
);
  import lbps_pkg::*;

  logic [15:0] tempo_pulse_r;
  logic        stg_vld_r;
  in_item_t    stg_item_r;
  logic        out_vld_r;
  out_item_t   out_item_r;
  seq_state_t  state_r;
  seq_state_t  state_nxt;
  out_item_t   res;
  logic        advance;
  logic        cfg_wr;

  // Configuration: writes land on the access phase; only paddr[2] selects a register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tempo_pulse_r <= TEMPO_PULSE_RESET;
    end else if (cfg_wr && cfg_paddr[2] == REG_TEMPO_PULSE) begin
      tempo_pulse_r <= cfg_pwdata[15:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TEMPO_PULSE) ? {16'd0, tempo_pulse_r} : 32'd0;

  // The staged item moves on when the result register is empty or being emptied.
  assign advance  = stg_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = stg_vld_r && !advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
    end else if (!in_stall) begin
      stg_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stg_item_r <= in_item;
    end
  end

  lbps_step u_step (
    .item           (stg_item_r),
    .st             (state_r),
    .tempo_pulse_ms (tempo_pulse_r),
    .st_nxt         (state_nxt),
    .res            (res)
  );

  // Pattern state changes only as an item passes into the result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_item  = out_item_r;

  // A stall on the input side only ever comes from a full result register that is held.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (stg_vld_r && out_vld_r && out_stall))
    else $error("input stalled without a held result");

  // The waiting result always matches the pattern state it left behind.
  a_result_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_item_r.led_on == state_r.lamp_lit
                   && out_item_r.active_pattern == state_r.cur_pattern))
    else $error("result item out of step with pattern state");

  // A trigger always lights the LED and drives the pin.
  a_trigger_lights: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && stg_item_r.func == FUNC_TRIGGER) |=> (out_item_r.led_on && out_item_r.led_write))
    else $error("trigger did not light the LED");

  // Without a write to the pin the LED level holds.
  a_no_write_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && !res.led_write) |-> (res.led_on == state_r.lamp_lit))
    else $error("LED level changed without a pin write");

endmodule
